### rtl/fzat_pkg.sv
`default_nettype none

package fzat_pkg;

	// Sample format and fixed widths
	localparam int SAMPLE_W   = 24;
	localparam int ANG_W      = 32;
	localparam int TAB_LEN    = 24;
	localparam int TAB_IDX_W  = 5;
	localparam int MUL_B_W    = 33;
	localparam int GAIN_W     = 23;
	localparam int BK_W       = 32;
	localparam int LEVEL_W    = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int DECAY_W    = 24;

	localparam int CORDIC_STEPS_DEF = 16;

	// Gain is 5 + 100 * drive in Q16
	localparam logic [GAIN_W-1:0] GAIN_BASE = GAIN_W'(5 * 65536);
	localparam logic [GAIN_W-1:0] GAIN_STEP = GAIN_W'(100);
	// 0.8 in Q0.16, 0.99 in Q0.24
	localparam logic [BK_W-1:0]    OFFSET_K = BK_W'(52429);
	localparam logic [DECAY_W-1:0] DECAY_K  = DECAY_W'(16609444);

	localparam logic [CFG_DATA_W-1:0] DRIVE_RST = CFG_DATA_W'(32768);
	localparam logic [LEVEL_W-1:0]    LEVEL_RST = LEVEL_W'(32768);
	localparam logic [CFG_DATA_W-1:0] BIAS_RST  = CFG_DATA_W'(32768);
	localparam logic [GAIN_W-1:0]     GAIN_RST  = GAIN_W'(5 * 65536 + 100 * 32768);
	localparam logic [BK_W-1:0]       BK_RST    = BK_W'(32768 * 52429);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DRIVE  = 2'd0,
		REG_LEVEL  = 2'd1,
		REG_OCTAVE = 2'd2,
		REG_BIAS   = 2'd3
	} fzat_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OFFSET,
		ST_BIAS,
		ST_GAIN,
		ST_CSTART,
		ST_CORDIC,
		ST_SCALE,
		ST_ROUND
	} fzat_state_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       end_of_block;
	} fzat_in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       end_of_block_out;
	} fzat_out_word_t;

	// atan(2^-i) in radians, Q30
	function automatic logic [ANG_W-2:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
		logic [ANG_W-2:0] v;
		case (idx)
			5'd0:  v = 31'd843314857;
			5'd1:  v = 31'd497837829;
			5'd2:  v = 31'd263043837;
			5'd3:  v = 31'd133525159;
			5'd4:  v = 31'd67021687;
			5'd5:  v = 31'd33543516;
			5'd6:  v = 31'd16775851;
			5'd7:  v = 31'd8388437;
			5'd8:  v = 31'd4194283;
			5'd9:  v = 31'd2097149;
			5'd10: v = 31'd1048576;
			5'd11: v = 31'd524288;
			5'd12: v = 31'd262144;
			5'd13: v = 31'd131072;
			5'd14: v = 31'd65536;
			5'd15: v = 31'd32768;
			5'd16: v = 31'd16384;
			5'd17: v = 31'd8192;
			5'd18: v = 31'd4096;
			5'd19: v = 31'd2048;
			5'd20: v = 31'd1024;
			5'd21: v = 31'd512;
			5'd22: v = 31'd256;
			5'd23: v = 31'd128;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

### rtl/fzat_mul.sv
`default_nettype none

module fzat_mul #(
	parameter int A_W = fzat_pkg::SAMPLE_W + 1,
	parameter int B_W = fzat_pkg::MUL_B_W
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic signed [A_W-1:0]  a,
	input  wire logic signed [B_W-1:0]  b,
	output logic signed [A_W+B_W-1:0]   p_q
);

	// Hold the product until the next issue
	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
		end
	end

endmodule

`default_nettype wire

### rtl/fzat_cordic.sv
`default_nettype none

module fzat_cordic #(
	parameter int XY_W  = fzat_pkg::SAMPLE_W + 26,
	parameter int STEPS = fzat_pkg::CORDIC_STEPS_DEF,
	parameter int X0_SH = fzat_pkg::SAMPLE_W + 15
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [XY_W-1:0]              y_init,
	output logic                                     done,
	output logic signed [fzat_pkg::ANG_W-1:0]        angle
);
	import fzat_pkg::*;

	localparam int STEP_W = $clog2(STEPS);

	logic                     run_q;
	logic                     done_q;
	logic [STEP_W-1:0]        step_q;
	logic signed [XY_W-1:0]   x_q;
	logic signed [XY_W-1:0]   y_q;
	logic signed [ANG_W-1:0]  ang_q;
	logic signed [XY_W-1:0]   xs;
	logic signed [XY_W-1:0]   ys;
	logic signed [ANG_W-1:0]  tab;

	assign xs  = x_q >>> step_q;
	assign ys  = y_q >>> step_q;
	assign tab = $signed({1'b0, atan_entry(TAB_IDX_W'(step_q))});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				if (step_q == STEP_W'(STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	// Rotate toward the x axis, one micro-rotation per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= XY_W'(1) <<< X0_SH;
			y_q   <= y_init;
			ang_q <= '0;
		end else if (run_q) begin
			if (!y_q[XY_W-1]) begin
				x_q   <= x_q + ys;
				y_q   <= y_q - xs;
				ang_q <= ang_q + tab;
			end else begin
				x_q   <= x_q - ys;
				y_q   <= y_q + xs;
				ang_q <= ang_q - tab;
			end
		end
	end

	assign done  = done_q;
	assign angle = ang_q;

endmodule

`default_nettype wire

### rtl/fuzz_atan_waveshaper_core.sv
`default_nettype none

// Channel   Signals                                     Direction  Moves
// sample    sample_valid / sample_ready / sample_word   in         one input sample word
// shaped    shaped_valid / shaped_ready / shaped_word   out        one shaped sample word
// config    cfg_we / cfg_index / cfg_data               in         one register write
//
// Each word passes through the sequencer from acceptance to the output register;
// the CORDIC loop of one shift-add stage, one rotation per cycle, sets most of
// that time, together with four trips through the shared multiplier.
// sample_ready is high only while the sequencer is idle.
// arst_n clears the sequencer, the envelope and the output valid, and resets the settings to their defaults.
// A stalled output holds its word; the sequencer waits in its final state
// until the output register frees up.

module fuzz_atan_waveshaper_core #(
	parameter int CORDIC_STEPS = fzat_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                sample_valid,
	output logic                                     sample_ready,
	input  wire fzat_pkg::fzat_in_word_t             sample_word,
	output logic                                     shaped_valid,
	input  wire logic                                shaped_ready,
	output fzat_pkg::fzat_out_word_t                 shaped_word,
	input  wire logic                                cfg_we,
	input  wire logic [fzat_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [fzat_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fzat_pkg::*;

	localparam int W     = SAMPLE_W;
	localparam int MA_W  = ((W > ANG_W - 1) ? W : ANG_W - 1) + 1;
	localparam int P_W   = MA_W + MUL_B_W;
	localparam int XY_W  = W + 26;
	localparam int SC_W  = 49;
	localparam int SC_SH = SC_W - W;
	localparam logic signed [W:0] RES_MAX = {2'b00, {(W-1){1'b1}}};
	localparam logic signed [W:0] RES_MIN = {2'b11, {(W-1){1'b0}}};

	// Settings; drive and bias are kept as their derived gain and offset factor
	logic [GAIN_W-1:0]  gain_q;
	logic [LEVEL_W-1:0] level_q;
	logic               octave_q;
	logic [BK_W-1:0]    bk_q;

	fzat_state_t state_q, state_d;

	logic signed [W-1:0] x_q;
	logic                eob_q;
	logic [W-1:0]        env_q;
	logic signed [W:0]   u_q;
	fzat_out_word_t      out_q;
	logic                out_valid_q;

	logic                    accept;
	logic                    out_free;
	logic [W-1:0]            mag_in;
	logic                    mul_en;
	logic signed [MA_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [P_W-1:0]   prod_q;
	logic                    cord_start;
	logic                    cord_done;
	logic signed [ANG_W-1:0] angle;
	logic                    ang_neg;
	logic [ANG_W-2:0]        ang_mag;
	logic [W+31:0]           off_sum;
	logic [W-1:0]            off;
	logic [SC_W-1:0]         rnd_sum;
	logic [W-1:0]            r_mag;
	logic signed [W:0]       res;
	logic signed [W:0]       res_sat;
	logic                    out_load;

	assign accept   = sample_valid && sample_ready;
	assign out_free = !out_valid_q || shaped_ready;
	assign sample_ready = (state_q == ST_IDLE);

	// Magnitude of the most negative sample still fits the unsigned envelope
	assign mag_in = sample_word.sample_in[W-1] ? W'(~sample_word.sample_in + 1'b1)
		: W'(sample_word.sample_in);

	// Offset = envelope * bias * 0.8, rounded half up
	assign off_sum = prod_q[W+31:0] + ((W+32)'(1) << 31);
	assign off     = off_sum[W+31:32];

	// Output scaling: |angle| * level / 4, rounded half up
	assign ang_neg = angle[ANG_W-1];
	assign ang_mag = ang_neg ? (ANG_W-1)'(-angle) : (ANG_W-1)'(angle);
	assign rnd_sum = SC_W'(prod_q[SC_W-2:0]) + (SC_W'(1) << (SC_SH - 1));
	assign r_mag   = rnd_sum[SC_W-1:SC_SH];

	// Restore the sign unless octave mode folds it, then clamp
	always_comb begin
		if (ang_neg && !octave_q) begin
			res = -$signed({1'b0, r_mag});
		end else begin
			res = $signed({1'b0, r_mag});
		end
		if (res > RES_MAX) begin
			res_sat = RES_MAX;
		end else if (res < RES_MIN) begin
			res_sat = RES_MIN;
		end else begin
			res_sat = res;
		end
	end

	fzat_mul #(
		.A_W (MA_W),
		.B_W (MUL_B_W)
	) u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	fzat_cordic #(
		.XY_W  (XY_W),
		.STEPS (CORDIC_STEPS),
		.X0_SH (W + 15)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.y_init (prod_q[XY_W-1:0]),
		.done   (cord_done),
		.angle  (angle)
	);

	// Settings registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RST;
			level_q  <= LEVEL_RST;
			octave_q <= 1'b0;
			bk_q     <= BK_RST;
		end else if (cfg_we) begin
			case (fzat_reg_t'(cfg_index))
				REG_DRIVE:  gain_q   <= GAIN_BASE + GAIN_W'(cfg_data) * GAIN_STEP;
				REG_LEVEL:  level_q  <= LEVEL_W'(cfg_data);
				REG_OCTAVE: octave_q <= cfg_data[0];
				REG_BIAS:   bk_q     <= BK_W'(cfg_data) * OFFSET_K;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: offset, decay, gain, CORDIC, scale, round
	always_comb begin
		state_d    = state_q;
		mul_en     = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		cord_start = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_OFFSET;
				end
			end
			ST_OFFSET: begin
				mul_en  = 1'b1;
				mul_a   = MA_W'(env_q);
				mul_b   = MUL_B_W'(bk_q);
				state_d = ST_BIAS;
			end
			ST_BIAS: begin
				// offset product is ready; issue the envelope decay
				mul_en  = 1'b1;
				mul_a   = MA_W'(env_q);
				mul_b   = MUL_B_W'(DECAY_K);
				state_d = ST_GAIN;
			end
			ST_GAIN: begin
				mul_en  = 1'b1;
				mul_a   = MA_W'(u_q);
				mul_b   = MUL_B_W'(gain_q);
				state_d = ST_CSTART;
			end
			ST_CSTART: begin
				cord_start = 1'b1;
				state_d    = ST_CORDIC;
			end
			ST_CORDIC: begin
				if (cord_done) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				mul_en  = 1'b1;
				mul_a   = MA_W'(ang_mag);
				mul_b   = MUL_B_W'(level_q);
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				// hold here while the previous word is still unclaimed
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Envelope: rise on accept, decay once the offset has used it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= '0;
		end else if (accept) begin
			if (mag_in > env_q) begin
				env_q <= mag_in;
			end
		end else if (state_q == ST_GAIN) begin
			env_q <= prod_q[W+23:24];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= sample_word.sample_in;
			eob_q <= sample_word.end_of_block;
		end
		if (state_q == ST_BIAS) begin
			u_q <= $signed({x_q[W-1], x_q}) + $signed({1'b0, off});
		end
		if (out_load) begin
			out_q.sample_out       <= res_sat[W-1:0];
			out_q.end_of_block_out <= eob_q;
		end
	end

	// Output register: drop valid when taken, raise on a new word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (shaped_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign shaped_valid = out_valid_q;
	assign shaped_word  = out_q;

endmodule

`default_nettype wire
